[rtl/core/wra_pkg.sv]
`default_nettype none

package wra_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 12;
    localparam int LEN_W      = 13;
    localparam int CODE_W     = 32;
    localparam int AVG_W      = 32;
    localparam int COUNT_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int NUM_W      = 49;
    localparam int DVD_W      = 48;
    localparam int QUO_W      = 32;
    localparam int DIV_STAGES = 32;
    localparam int LIMIT_W    = 17;

    localparam logic [COUNT_W-1:0] TARGET_RESET = 16'd20;

    // travels alongside a word through the arithmetic stages
    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic               last;
        logic [COUNT_W-1:0] done;
        logic               we;
        logic               neg;
    } side_t;

    typedef struct packed {
        logic [COUNT_W-1:0] rem;
        logic [QUO_W-1:0]   low;
    } div_word_t;

    typedef struct packed {
        logic [AVG_W-1:0]   avg;
        logic [INDEX_W-1:0] idx;
        logic               last;
        logic [COUNT_W-1:0] done;
    } out_word_t;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    function automatic div_word_t div_step(div_word_t w, logic [COUNT_W-1:0] d);
        logic [COUNT_W:0] t;
        logic [COUNT_W:0] diff;
        div_word_t        r;
        t    = {w.rem, w.low[QUO_W-1]};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            r.rem = diff[COUNT_W-1:0];
            r.low = {w.low[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[COUNT_W-1:0];
            r.low = {w.low[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/wra_if.sv]
`default_nettype none

interface wra_in_if import wra_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [INDEX_W-1:0]         sample_index;
    logic [LEN_W-1:0]           record_length;
    logic [CODE_W-1:0]          probe_code;
    logic [CODE_W-1:0]          spacing_code;

    modport source (output valid, sample_value, sample_index, record_length,
                    probe_code, spacing_code, input ready);
    modport sink   (input valid, sample_value, sample_index, record_length,
                    probe_code, spacing_code, output ready);
endinterface

interface wra_out_if import wra_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [AVG_W-1:0] average_value;
    logic [INDEX_W-1:0]      out_index;
    logic                    last_of_record;
    logic [COUNT_W-1:0]      averages_done;

    modport source (output valid, average_value, out_index, last_of_record,
                    averages_done, input ready);
    modport sink   (input valid, average_value, out_index, last_of_record,
                    averages_done, output ready);
endinterface

interface wra_cfg_if import wra_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] target_averages;

    modport source (output valid, target_averages, input ready);
    modport sink   (input valid, target_averages, output ready);
endinterface

`default_nettype wire

[rtl/core/wra_ram.sv]
`default_nettype none

module wra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/wra_div.sv]
`default_nettype none

module wra_div import wra_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [DVD_W-1:0]   in_dvd,
    input  logic [COUNT_W-1:0] in_d,
    input  side_t              in_side,
    input  logic [INDEX_W-1:0] probe_idx,
    output logic               probe_hit,
    output logic               out_vld,
    output logic [QUO_W-1:0]   out_quo,
    output side_t              out_side
);

    logic               vld_reg  [DIV_STAGES];
    div_word_t          word_reg [DIV_STAGES];
    div_word_t          word_next[DIV_STAGES];
    logic [COUNT_W-1:0] d_reg    [DIV_STAGES];
    side_t              side_reg [DIV_STAGES];

    // dividend is below d * 2^32, so its top part already sits below d
    assign word_next[0] = div_step({in_dvd[DVD_W-1:QUO_W], in_dvd[QUO_W-1:0]}, in_d);

    for (genvar j = 1; j < DIV_STAGES; j++)
    begin : g_step
        assign word_next[j] = div_step(word_reg[j-1], d_reg[j-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DIV_STAGES; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int j = 1; j < DIV_STAGES; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg[0] <= word_next[0];
            d_reg[0]    <= in_d;
            side_reg[0] <= in_side;
            for (int j = 1; j < DIV_STAGES; j++)
            begin
                word_reg[j] <= word_next[j];
                d_reg[j]    <= d_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // any word in flight that will write the probed entry
    always_comb
    begin
        probe_hit = 1'b0;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (vld_reg[j] && side_reg[j].we && side_reg[j].idx == probe_idx)
            begin
                probe_hit = 1'b1;
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_quo  = word_reg[DIV_STAGES-1].low;
    assign out_side = side_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

[rtl/core/wra_outq.sv]
`default_nettype none

module wra_outq import wra_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  out_word_t    push_word,
    output logic         full,
    wra_out_if.source    results
);

    out_word_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;
    out_word_t  head;

    assign pop  = results.valid && results.ready;
    assign full = (count_reg == 2'd2);
    assign head = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign results.valid          = (count_reg != 2'd0);
    assign results.average_value  = head.avg;
    assign results.out_index      = head.idx;
    assign results.last_of_record = head.last;
    assign results.averages_done  = head.done;

endmodule

`default_nettype wire

[rtl/core/waveform_running_average_top.sv]
`default_nettype none

// channel   dir  width  carries
// samples   in   105    sample_value, sample_index, record_length, probe_code, spacing_code
// results   out  61     average_value, out_index, last_of_record, averages_done
// cfg       in   16     target_averages (zero is ignored)
//
// One word enters per cycle unless a stall holds it; each passes through store read,
// multiply, rounding add and a 32-stage divider by weight + 1 and is then written back
// to the store. A word whose index is still in flight to the store waits until that
// write lands.
// Reset clears the record state and sets the target to 20; the store is not cleared.
// A stalled result is held in a two-word queue; the pipeline stops only when it fills.

module waveform_running_average_top import wra_pkg::*; #(
    parameter int MAX_POINTS = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    wra_in_if.sink    samples,
    wra_out_if.source results,
    wra_cfg_if.sink   cfg
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam logic [LIMIT_W-1:0] DEPTH_LIMIT = LIMIT_W'(MAX_POINTS);

    logic [COUNT_W-1:0] target_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] weight_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [CODE_W-1:0]  probe_reg;
    logic [CODE_W-1:0]  spacing_reg;

    logic               en;
    logic               full;
    logic               accept;
    logic               hazard;
    logic               probe_hit;
    logic               first;
    logic               changed;
    logic [COUNT_W-1:0] cnt_base;
    logic [COUNT_W-1:0] clamped;
    logic [COUNT_W-1:0] cnt_cur;
    logic [COUNT_W-1:0] k;
    logic               is_last;
    logic               in_range;

    logic                a_vld_reg;
    logic [SAMPLE_W-1:0] a_x_reg;
    logic [COUNT_W-1:0]  a_k_reg;
    side_t               a_side_reg;

    logic                b_vld_reg;
    logic [NUM_W-1:0]    b_num_reg;
    logic [COUNT_W-1:0]  b_d_reg;
    side_t               b_side_reg;
    logic [NUM_W-1:0]    b_num_next;
    logic [AVG_W-1:0]    old;

    logic                c_vld_reg;
    logic [DVD_W-1:0]    c_dvd_reg;
    logic [COUNT_W-1:0]  c_d_reg;
    side_t               c_side_reg;
    side_t               c_side_next;
    logic [NUM_W-1:0]    mag;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [AVG_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [AVG_W-1:0]    ram_rdata;

    logic                d_vld;
    logic [QUO_W-1:0]    d_quo;
    side_t               d_side;
    out_word_t           push_word;

    assign en = !full;

    // record bookkeeping, all settled as the word is taken
    assign first    = (samples.sample_index == '0);
    assign changed  = (samples.record_length != len_reg) ||
                      (samples.probe_code != probe_reg) ||
                      (samples.spacing_code != spacing_reg);
    assign cnt_base = changed ? '0 : count_reg;
    assign clamped  = (cnt_base >= target_reg) ? target_reg - COUNT_W'(1) : cnt_base;
    assign cnt_cur  = first ? clamped : count_reg;
    assign k        = first ? clamped : weight_reg;
    assign is_last  = (samples.record_length != '0) &&
                      ({1'b0, samples.sample_index} == samples.record_length - LEN_W'(1));
    assign in_range = (LIMIT_W'(samples.sample_index) < DEPTH_LIMIT);
    assign count_next = (is_last && cnt_cur != '1) ? cnt_cur + COUNT_W'(1) : cnt_cur;

    // hold the word while an earlier one still has to write the same entry
    assign hazard = probe_hit ||
                    (a_vld_reg && a_side_reg.we && a_side_reg.idx == samples.sample_index) ||
                    (b_vld_reg && b_side_reg.we && b_side_reg.idx == samples.sample_index) ||
                    (c_vld_reg && c_side_reg.we && c_side_reg.idx == samples.sample_index);

    assign samples.ready = en && !hazard;
    assign accept        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= TARGET_RESET;
            count_reg   <= '0;
            weight_reg  <= '0;
            len_reg     <= '0;
            probe_reg   <= '0;
            spacing_reg <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.target_averages != '0)
            begin
                target_reg <= cfg.target_averages;
            end
            if (accept)
            begin
                count_reg <= count_next;
                if (first)
                begin
                    weight_reg  <= clamped;
                    len_reg     <= samples.record_length;
                    probe_reg   <= samples.probe_code;
                    spacing_reg <= samples.spacing_code;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= accept;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    // old * k + x in Q16.16; an unused weight drops the store read
    assign old = (a_k_reg != '0) ? ram_rdata : '0;
    assign b_num_next = {{(NUM_W-AVG_W){old[AVG_W-1]}}, old} *
                        {{(NUM_W-COUNT_W){1'b0}}, a_k_reg} +
                        {{(NUM_W-SAMPLE_W-FRAC_W){a_x_reg[SAMPLE_W-1]}}, a_x_reg,
                         {FRAC_W{1'b0}}};

    // round half away from zero on the magnitude
    assign mag = b_num_reg[NUM_W-1] ? -b_num_reg : b_num_reg;

    always_comb
    begin
        c_side_next     = b_side_reg;
        c_side_next.neg = b_num_reg[NUM_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (accept)
            begin
                a_x_reg         <= samples.sample_value;
                a_k_reg         <= in_range ? k : '0;
                a_side_reg.idx  <= samples.sample_index;
                a_side_reg.last <= is_last;
                a_side_reg.done <= k + COUNT_W'(1);
                a_side_reg.we   <= in_range;
                a_side_reg.neg  <= 1'b0;
            end
            b_num_reg      <= b_num_next;
            b_d_reg        <= a_k_reg + COUNT_W'(1);
            b_side_reg     <= a_side_reg;
            c_dvd_reg      <= mag[DVD_W-1:0] + DVD_W'(b_d_reg >> 1);
            c_d_reg        <= b_d_reg;
            c_side_reg     <= c_side_next;
        end
    end

    assign ram_re    = accept;
    assign ram_raddr = ADDR_W'(samples.sample_index);

    wra_ram #(
        .WIDTH (AVG_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wra_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (c_vld_reg),
        .in_dvd    (c_dvd_reg),
        .in_d      (c_d_reg),
        .in_side   (c_side_reg),
        .probe_idx (samples.sample_index),
        .probe_hit (probe_hit),
        .out_vld   (d_vld),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    assign ram_wdata = d_side.neg ? -d_quo : d_quo;
    assign ram_waddr = ADDR_W'(d_side.idx);
    assign ram_we    = en && d_vld && d_side.we;

    assign push_word.avg  = ram_wdata;
    assign push_word.idx  = d_side.idx;
    assign push_word.last = d_side.last;
    assign push_word.done = d_side.done;

    wra_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (en && d_vld),
        .push_word (push_word),
        .full      (full),
        .results   (results)
    );

    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re && ram_we |-> ram_raddr != ram_waddr)
        else $error("store read and write hit the same entry");

    a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ram_re |=> $stable(ram_rdata))
        else $error("store read data moved without a read");

    a_weight_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        accept && first |=> weight_reg < $past(target_reg))
        else $error("weight latched at or above target");

    a_done_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.averages_done != '0)
        else $error("result carries a zero average count");

endmodule

`default_nettype wire
